/* rtl/pqi2d_pkg.sv */
// shared types and register indexes for the periodic quadratic interpolation unit
package pqi2d_pkg;

   typedef struct packed {
      logic               cmd;
      logic [7:0]         pixel_col;
      logic [7:0]         pixel_row;
      logic signed [15:0] pixel_value;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
   } pqi2d_req_type;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               saturated;
   } pqi2d_rsp_type;

   // one job between front and back: a pixel write or a wrapped query
   typedef struct packed {
      logic        query;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [15:0] value;
      logic [15:0] frac_a;
      logic [15:0] frac_b;
   } pqi2d_job_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;

endpackage

/* rtl/pqi2d_ram.sv */
// generic single-port ram with registered read
module pqi2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/pqi2d_queue.sv */
// small register queue of jobs between front and back
module pqi2d_queue
   import pqi2d_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  pqi2d_job_type push_data,
   input  logic          push_valid,
   output logic          push_ready,
   output pqi2d_job_type pop_data,
   output logic          pop_valid,
   input  logic          pop_ready
);

   localparam int PTW = $clog2(DEPTH);
   localparam int CNW = $clog2(DEPTH + 1);

   pqi2d_job_type  entry_ff [DEPTH];
   logic [PTW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0] count_ff, count_in;
   logic           push, pop;

   assign push_ready = count_ff != CNW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNW'(push) - CNW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/pqi2d_front.sv */
// front end: takes request beats, wraps query positions, issues jobs
module pqi2d_front
   import pqi2d_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int PIXEL_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  pqi2d_req_type req_data,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [8:0]    width_eff,
   input  logic [8:0]    height_eff,
   output pqi2d_job_type job_data,
   output logic          job_valid,
   input  logic          job_ready
);

   localparam int SW = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [1:0]      step_ff, step_in;
   logic [15:0]     dvd_x_ff, dvd_x_in, dvd_y_ff, dvd_y_in;
   logic [8:0]      rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic            neg_x_ff, neg_y_ff;
   logic [15:0]     frac_a_ff, frac_b_ff;
   logic [8:0]      wrap_x, wrap_y;
   logic            accept, in_range;
   logic [15:0]     stored_value;

   // four restoring steps of the remainder, msb first
   function automatic logic [8:0] rem_step4(input logic [8:0] rem, input logic [3:0] bits,
                                            input logic [8:0] n);
      logic [9:0] t;
      logic [8:0] r;
      r = rem;
      for (int k = 3; k >= 0; k--) begin
         t = {r, bits[k]};
         if (t >= {1'b0, n}) begin
            t = t - {1'b0, n};
         end
         r = t[8:0];
      end
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && job_ready;
   assign in_range  = (32'(req_data.pixel_col) < 32'(MAX_WIDTH)) &&
                      (32'(req_data.pixel_row) < 32'(MAX_HEIGHT));
   assign stored_value = 16'($signed(req_data.pixel_value[SW-1:0]));

   // negative integer part folds back as period minus remainder
   assign wrap_x = (neg_x_ff && rem_x_ff != '0) ? width_eff - rem_x_ff : rem_x_ff;
   assign wrap_y = (neg_y_ff && rem_y_ff != '0) ? height_eff - rem_y_ff : rem_y_ff;

   always_comb begin
      job_data  = '0;
      job_valid = 1'b0;
      if (state_ff == ST_FIN) begin
         job_valid       = 1'b1;
         job_data.query  = 1'b1;
         job_data.col    = wrap_x[7:0];
         job_data.row    = wrap_y[7:0];
         job_data.frac_a = frac_a_ff;
         job_data.frac_b = frac_b_ff;
      end else if (state_ff == ST_IDLE) begin
         job_valid      = req_valid && (req_data.cmd == CMD_WRITE) && in_range;
         job_data.col   = req_data.pixel_col;
         job_data.row   = req_data.pixel_row;
         job_data.value = stored_value;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dvd_x_in = dvd_x_ff;
      dvd_y_in = dvd_y_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.cmd == CMD_QUERY) begin
               state_in = ST_DIV;
               step_in  = '0;
               rem_x_in = '0;
               rem_y_in = '0;
               dvd_x_in = req_data.coord_x[31] ? 16'(-req_data.coord_x[31:16])
                                               : req_data.coord_x[31:16];
               dvd_y_in = req_data.coord_y[31] ? 16'(-req_data.coord_y[31:16])
                                               : req_data.coord_y[31:16];
            end
         end
         ST_DIV: begin
            rem_x_in = rem_step4(rem_x_ff, dvd_x_ff[15:12], width_eff);
            rem_y_in = rem_step4(rem_y_ff, dvd_y_ff[15:12], height_eff);
            dvd_x_in = {dvd_x_ff[11:0], 4'b0000};
            dvd_y_in = {dvd_y_ff[11:0], 4'b0000};
            step_in  = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (job_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_x_ff <= dvd_x_in;
      dvd_y_ff <= dvd_y_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      if (accept) begin
         neg_x_ff  <= req_data.coord_x[31];
         neg_y_ff  <= req_data.coord_y[31];
         frac_a_ff <= req_data.coord_x[15:0];
         frac_b_ff <= req_data.coord_y[15:0];
      end
   end

   a_rem_x_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (rem_x_ff < width_eff) && (rem_y_ff < height_eff))
      else $error("remainder not below period");
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken while wrapping a query");
   a_fin_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_FIN) |-> $past(state_ff == ST_DIV) && $past(step_ff == 2'd3))
      else $error("query issued before remainder complete");

endmodule

/* rtl/pqi2d_back.sv */
// back end: reads the six pixels, runs the arithmetic pipeline, buffers results
module pqi2d_back
   import pqi2d_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int PIXEL_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [8:0]    width_eff,
   input  logic [8:0]    height_eff,
   input  pqi2d_job_type job_data,
   input  logic          job_valid,
   output logic          job_ready,
   output pqi2d_rsp_type rsp_data,
   output logic          rsp_valid,
   input  logic          rsp_ready
);

   localparam int SW  = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
   localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int DW  = SW + 3;
   localparam int XW  = DW + 21;
   localparam int RW  = XW - 8;
   localparam int PW  = RW + 17;
   localparam int ACW = PW + 2;
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTW   = $clog2(RQ_DEPTH);
   localparam int RQ_CNW   = $clog2(RQ_DEPTH + 1);

   localparam logic [2:0] RD_F0 = 3'd0;
   localparam logic [2:0] RD_R  = 3'd1;
   localparam logic [2:0] RD_L  = 3'd2;
   localparam logic [2:0] RD_U  = 3'd3;
   localparam logic [2:0] RD_D  = 3'd4;
   localparam logic [2:0] RD_G  = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [2:0]     rd_cnt_ff, rd_cnt_in;
   logic [7:0]     i_ff, j_ff, ip1_ff, im1_ff, jp1_ff, jm1_ff;
   logic [15:0]    a_ff, b_ff;
   logic [8:0]     ip1_w, jp1_w;
   logic           pop, start, ram_en, ram_we;
   logic [7:0]     rd_col, rd_row;
   logic [AW-1:0]  ram_addr;
   logic [SW-1:0]  ram_rdata;
   logic           rv_ff;
   logic [2:0]     ridx_ff;
   logic signed [SW-1:0] f0_ff, r_ff, l_ff, u_ff, d_ff, g_w;

   logic [RQ_CNW-1:0] inflight_ff, inflight_in;

   // arithmetic pipeline
   logic                 s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic signed [DW-1:0] s1_c1_ff, s1_s2_ff, s1_c3_ff, s1_s4_ff, s1_c5_ff;
   logic signed [SW-1:0] s1_f0_ff, s2_f0_ff, s3_f0_ff, s4_f0_ff;
   logic [15:0]          s1_a_ff, s1_b_ff, s2_a_ff, s2_b_ff, s3_a_ff, s3_b_ff;
   logic signed [17:0]   am_w, bm_w, b2_w;
   logic signed [DW-1:0] s2_c1_ff, s2_c3_ff;
   logic signed [DW+18:0] p_as2_ff, p_bc5_ff, p_bs4_ff;
   logic signed [XW-1:0] x_w, y_w;
   logic signed [RW-1:0] s3_xr_ff, s3_yr_ff;
   logic signed [PW-1:0] s4_pa_ff, s4_pb_ff;
   logic signed [ACW-1:0] s5_acc_ff;
   logic signed [63:0]   res_w;
   pqi2d_rsp_type        res_rsp;

   // result buffer
   pqi2d_rsp_type     rq_ff [RQ_DEPTH];
   logic [RQ_PTW-1:0] rq_wr_ff, rq_rd_ff;
   logic [RQ_CNW-1:0] rq_cnt_ff;
   logic              rq_push, rsp_take;

   // a query starts only with room left for its result
   assign job_ready = (state_ff == ST_IDLE) &&
                      (!job_data.query || inflight_ff < RQ_CNW'(RQ_DEPTH));
   assign pop   = job_valid && job_ready;
   assign start = pop && job_data.query;
   assign ram_we = pop && !job_data.query;
   assign ram_en = ram_we || (state_ff == ST_READ);

   assign ip1_w = 9'(job_data.col) + 9'd1;
   assign jp1_w = 9'(job_data.row) + 9'd1;

   always_comb begin
      rd_col = i_ff;
      rd_row = j_ff;
      case (rd_cnt_ff)
         RD_F0: begin rd_col = i_ff;   rd_row = j_ff;   end
         RD_R:  begin rd_col = ip1_ff; rd_row = j_ff;   end
         RD_L:  begin rd_col = im1_ff; rd_row = j_ff;   end
         RD_U:  begin rd_col = i_ff;   rd_row = jp1_ff; end
         RD_D:  begin rd_col = i_ff;   rd_row = jm1_ff; end
         RD_G:  begin rd_col = ip1_ff; rd_row = jp1_ff; end
         default: begin rd_col = i_ff; rd_row = j_ff; end
      endcase
      if (state_ff == ST_IDLE) begin
         ram_addr = AW'(job_data.row) * AW'(MAX_WIDTH) + AW'(job_data.col);
      end else begin
         ram_addr = AW'(rd_row) * AW'(MAX_WIDTH) + AW'(rd_col);
      end
   end

   pqi2d_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_image (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (job_data.value[SW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in  = ST_READ;
               rd_cnt_in = RD_F0;
            end
         end
         ST_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == RD_G) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_cnt_ff <= RD_F0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_cnt_ff <= rd_cnt_in;
         rv_ff     <= state_ff == ST_READ;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= rd_cnt_ff;
      if (start) begin
         i_ff   <= job_data.col;
         j_ff   <= job_data.row;
         ip1_ff <= (ip1_w >= width_eff) ? 8'(ip1_w - width_eff) : ip1_w[7:0];
         jp1_ff <= (jp1_w >= height_eff) ? 8'(jp1_w - height_eff) : jp1_w[7:0];
         im1_ff <= (job_data.col == 8'd0) ? 8'(width_eff - 9'd1) : job_data.col - 8'd1;
         jm1_ff <= (job_data.row == 8'd0) ? 8'(height_eff - 9'd1) : job_data.row - 8'd1;
         a_ff   <= job_data.frac_a;
         b_ff   <= job_data.frac_b;
      end
      if (rv_ff) begin
         case (ridx_ff)
            RD_F0:   f0_ff <= ram_rdata;
            RD_R:    r_ff  <= ram_rdata;
            RD_L:    l_ff  <= ram_rdata;
            RD_U:    u_ff  <= ram_rdata;
            RD_D:    d_ff  <= ram_rdata;
            default: ;
         endcase
      end
   end

   assign g_w = ram_rdata;

   // stage 1: differences
   always_ff @(posedge clock) begin
      s1_c1_ff <= DW'(r_ff) - DW'(f0_ff);
      s1_s2_ff <= DW'(r_ff) + DW'(l_ff) - (DW'(f0_ff) <<< 1);
      s1_c3_ff <= DW'(u_ff) - DW'(f0_ff);
      s1_s4_ff <= DW'(u_ff) + DW'(d_ff) - (DW'(f0_ff) <<< 1);
      s1_c5_ff <= DW'(g_w) - DW'(r_ff) - DW'(u_ff) + DW'(f0_ff);
      s1_f0_ff <= f0_ff;
      s1_a_ff  <= a_ff;
      s1_b_ff  <= b_ff;
   end

   // stage 2: fraction products
   assign am_w = $signed({2'b00, s1_a_ff}) - 18'sd65536;
   assign bm_w = $signed({2'b00, s1_b_ff}) - 18'sd65536;
   assign b2_w = $signed({1'b0, s1_b_ff, 1'b0});

   always_ff @(posedge clock) begin
      p_as2_ff <= (DW+19)'(am_w) * (DW+19)'(s1_s2_ff);
      p_bc5_ff <= (DW+19)'(b2_w) * (DW+19)'(s1_c5_ff);
      p_bs4_ff <= (DW+19)'(bm_w) * (DW+19)'(s1_s4_ff);
      s2_c1_ff <= s1_c1_ff;
      s2_c3_ff <= s1_c3_ff;
      s2_f0_ff <= s1_f0_ff;
      s2_a_ff  <= s1_a_ff;
      s2_b_ff  <= s1_b_ff;
   end

   // stage 3: slope sums, floored to 8 fewer fraction bits
   assign x_w = (XW'(s2_c1_ff) <<< 17) + XW'(p_as2_ff) + XW'(p_bc5_ff);
   assign y_w = (XW'(s2_c3_ff) <<< 17) + XW'(p_bs4_ff);

   always_ff @(posedge clock) begin
      s3_xr_ff <= RW'(x_w >>> 8);
      s3_yr_ff <= RW'(y_w >>> 8);
      s3_f0_ff <= s2_f0_ff;
      s3_a_ff  <= s2_a_ff;
      s3_b_ff  <= s2_b_ff;
   end

   // stage 4: weight by fractions
   always_ff @(posedge clock) begin
      s4_pa_ff <= PW'($signed({1'b0, s3_a_ff})) * PW'(s3_xr_ff);
      s4_pb_ff <= PW'($signed({1'b0, s3_b_ff})) * PW'(s3_yr_ff);
      s4_f0_ff <= s3_f0_ff;
   end

   // stage 5: accumulate with rounding offset
   always_ff @(posedge clock) begin
      s5_acc_ff <= (ACW'(s4_f0_ff) <<< 25) + ACW'(s4_pa_ff) + ACW'(s4_pb_ff) +
                   (ACW'(1) <<< 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= rv_ff && (ridx_ff == RD_G);
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   // stage 6: scale and clip into the result buffer
   always_comb begin
      res_w = 64'(s5_acc_ff >>> 17);
      res_rsp.saturated = 1'b0;
      res_rsp.sample_value = res_w[31:0];
      if (res_w > 64'sd2147483647) begin
         res_rsp.sample_value = 32'sh7FFFFFFF;
         res_rsp.saturated    = 1'b1;
      end else if (res_w < -64'sd2147483648) begin
         res_rsp.sample_value = 32'sh80000000;
         res_rsp.saturated    = 1'b1;
      end
   end

   assign rq_push   = s5_v_ff;
   assign rsp_valid = rq_cnt_ff != '0;
   assign rsp_data  = rq_ff[rq_rd_ff];
   assign rsp_take  = rsp_valid && rsp_ready;

   always_comb begin
      inflight_in = inflight_ff + RQ_CNW'(start) - RQ_CNW'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_cnt_ff   <= '0;
         inflight_ff <= '0;
      end else begin
         rq_wr_ff    <= rq_push ? rq_wr_ff + RQ_PTW'(1) : rq_wr_ff;
         rq_rd_ff    <= rsp_take ? rq_rd_ff + RQ_PTW'(1) : rq_rd_ff;
         rq_cnt_ff   <= rq_cnt_ff + RQ_CNW'(rq_push) - RQ_CNW'(rsp_take);
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= res_rsp;
      end
   end

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= RQ_CNW'(RQ_DEPTH))
      else $error("more queries in flight than result slots");
   a_buffer_covers: assert property (@(posedge clock) disable iff (reset)
      rq_cnt_ff <= inflight_ff)
      else $error("buffered results exceed queries in flight");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      rq_push |-> rq_cnt_ff != RQ_CNW'(RQ_DEPTH) || rsp_take)
      else $error("result pushed into full buffer");
   a_read_sequence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) && (rd_cnt_ff != RD_G) |=> (state_ff == ST_READ))
      else $error("pixel read sequence cut short");

endmodule

/* rtl/periodic_quadratic_interp_2d_unit.sv */
// top level of the periodic quadratic interpolation unit
//
// Holds an image written one pixel per request beat (cmd 0) and answers sample
// queries (cmd 1) at a signed Q16.16 position, wrapped periodically over the
// configured width and height, with one response beat carrying a saturated value
// with 8 fraction bits. Writes are taken on every cycle unless the front is busy
// with a query or the job queue is full. A query is first held in the front while
// it reduces the integer position modulo the period four bits a cycle; then the
// back takes the job and uses the single image memory port to read the centre and
// five neighbouring pixels, and it takes the next job only once these reads are
// done. Once four queries are in flight, started but with results not yet taken,
// the back stops starting queries. Registers: index 0 sets the width in use,
// index 1 the height; zero counts as one and values above the maximum as the
// maximum. Write them only while the unit is idle. Pixels never written read as
// undefined values.
module periodic_quadratic_interp_2d_unit
   import pqi2d_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int PIXEL_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  pqi2d_req_type req_data,
   input  logic          req_valid,
   output logic          req_ready,
   output pqi2d_rsp_type rsp_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic [1:0]    csr_index,
   input  logic [8:0]    csr_wdata,
   input  logic          csr_valid,
   output logic          csr_ready
);

   localparam int MAXW_EFF = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int MAXH_EFF = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

   logic [8:0]    width_ff, height_ff;
   logic [8:0]    width_eff, height_eff;
   pqi2d_job_type fr_job, bk_job;
   logic          fr_valid, fr_ready, bk_valid, bk_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      width_eff = width_ff;
      if (width_ff == 9'd0) begin
         width_eff = 9'd1;
      end else if (width_ff > 9'(MAXW_EFF)) begin
         width_eff = 9'(MAXW_EFF);
      end
      height_eff = height_ff;
      if (height_ff == 9'd0) begin
         height_eff = 9'd1;
      end else if (height_ff > 9'(MAXH_EFF)) begin
         height_eff = 9'(MAXH_EFF);
      end
   end

   pqi2d_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .job_data   (fr_job),
      .job_valid  (fr_valid),
      .job_ready  (fr_ready)
   );

   pqi2d_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (fr_job),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .pop_data   (bk_job),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready)
   );

   pqi2d_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .job_data   (bk_job),
      .job_valid  (bk_valid),
      .job_ready  (bk_ready),
      .rsp_data   (rsp_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready)
   );

endmodule
